// ===== rtl/assert_macros.svh =====
// Assertion macros used by the gyro bias correction sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check prop on every clock edge outside reset.
`define GBC_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Check that cond never holds outside reset.
`define GBC_NEVER(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define GBC_ASSERT(name, prop, msg)
`define GBC_NEVER(name, cond, msg)
`endif
`endif

// ===== rtl/gbc_pkg.sv =====
// Types, constants and helpers for the gyro rate bias correction block.
`default_nettype none
package gbc_pkg;

	localparam int COUNT_BITS_DEF = 16;
	localparam int FRAC_BITS      = 8;
	localparam int VAL_BITS       = 20;
	localparam int PADDR_W        = 4;

	// dps per LSB times 2^(16+FRAC_BITS), 16.4 LSB per dps, rounded
	localparam logic [23:0] SCALE_RESET =
		24'(((64'd655360 << FRAC_BITS) + 64'd82) / 64'd164);

	localparam logic signed [VAL_BITS-1:0] VAL_MAX = 20'sh7FFFF;
	localparam logic signed [VAL_BITS-1:0] VAL_MIN = 20'sh80000;

	localparam logic [1:0] REG_SCALE  = 2'd0;
	localparam logic [1:0] REG_INVERT = 2'd1;
	localparam logic [1:0] REG_LEARN  = 2'd2;

	typedef enum logic [1:0] {
		FUNC_SAMPLE     = 2'd0,
		FUNC_CAL_START  = 2'd1,
		FUNC_CAL_FINISH = 2'd2,
		FUNC_LEARN      = 2'd3
	} func_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_SAMPLE,
		ST_MUL_LEARN,
		ST_SCALE,
		ST_RATE,
		ST_LEARN,
		ST_START,
		ST_FAIL,
		ST_DIV_LOAD,
		ST_DIV,
		ST_DIV_END,
		ST_WRITE
	} state_t;

	typedef struct packed {
		logic capture;
		logic mul;
		logic mul_learn;
		logic scale;
		logic rate;
		logic learn;
		logic cal_start;
		logic cal_fail;
		logic div_load;
		logic div_step;
		logic div_end;
		logic load_out;
		logic ok;
	} cmd_t;

	typedef struct packed {
		logic cal_active;
		logic count_zero;
	} stat_t;

	function automatic logic signed [VAL_BITS-1:0] sat_val(input logic signed [31:0] v);
		logic signed [VAL_BITS-1:0] r;
		if (v > 32'sd524287) begin
			r = VAL_MAX;
		end else if (v < -32'sd524288) begin
			r = VAL_MIN;
		end else begin
			r = v[VAL_BITS-1:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/gbc_ctrl.sv =====
// Sequencer for the gyro bias correction block.
`default_nettype none
`include "assert_macros.svh"
module gbc_ctrl #(
	parameter int COUNT_BITS = gbc_pkg::COUNT_BITS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [1:0]    func,
	input  wire logic          read_ok,
	output logic               out_valid,
	input  wire logic          out_ready,
	input  wire gbc_pkg::stat_t stat,
	output gbc_pkg::cmd_t      cmd
);
	import gbc_pkg::*;

	localparam int SUM_BITS = VAL_BITS + COUNT_BITS;
	localparam int CNT_W    = $clog2(SUM_BITS);

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             ok_q, ok_d;
	logic             out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ok_d    = 1'b1;
		cmd     = '0;
		cmd.ok  = ok_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					unique case (func_t'(func))
						FUNC_SAMPLE: begin
							if (read_ok) begin
								state_d = ST_MUL_SAMPLE;
							end else begin
								ok_d    = 1'b0;
								state_d = ST_WRITE;
							end
						end
						FUNC_CAL_START: state_d = ST_START;
						FUNC_CAL_FINISH: begin
							if (!stat.cal_active) begin
								ok_d    = 1'b0;
								state_d = ST_WRITE;
							end else if (stat.count_zero) begin
								ok_d    = 1'b0;
								state_d = ST_FAIL;
							end else begin
								state_d = ST_DIV_LOAD;
							end
						end
						FUNC_LEARN: state_d = ST_MUL_LEARN;
					endcase
				end
			end
			ST_MUL_SAMPLE: begin
				cmd.mul = 1'b1;
				state_d = ST_SCALE;
			end
			ST_MUL_LEARN: begin
				cmd.mul       = 1'b1;
				cmd.mul_learn = 1'b1;
				state_d       = ST_LEARN;
			end
			ST_SCALE: begin
				cmd.scale = 1'b1;
				state_d   = ST_RATE;
			end
			ST_RATE: begin
				cmd.rate = 1'b1;
				state_d  = ST_WRITE;
			end
			ST_LEARN: begin
				cmd.learn = 1'b1;
				state_d   = ST_WRITE;
			end
			ST_START: begin
				cmd.cal_start = 1'b1;
				state_d       = ST_WRITE;
			end
			ST_FAIL: begin
				cmd.cal_fail = 1'b1;
				state_d      = ST_WRITE;
			end
			ST_DIV_LOAD: begin
				cmd.div_load = 1'b1;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == '0) begin
					state_d = ST_DIV_END;
				end
			end
			ST_DIV_END: begin
				cmd.div_end = 1'b1;
				state_d     = ST_WRITE;
			end
			ST_WRITE: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Count divider steps, one quotient bit each.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (state_q == ST_DIV_LOAD) begin
			cnt_q <= CNT_W'(SUM_BITS - 1);
		end else if (state_q == ST_DIV) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.capture) begin
				ok_q <= ok_d;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	`GBC_ASSERT(a_one_item, in_valid && in_ready |=> !in_ready, "second item taken mid-work")
	`GBC_ASSERT(a_div_len, state_q == ST_DIV && cnt_q == '0 |=> state_q == ST_DIV_END, "divider overrun")
	`GBC_ASSERT(a_load_valid, cmd.load_out |=> out_valid_q, "loaded result not shown")
	`GBC_NEVER(a_no_overwrite, cmd.load_out && out_valid_q && !out_ready, "pending result overwritten")

endmodule
`default_nettype wire

// ===== rtl/gbc_datapath.sv =====
// State registers, shared multiplier and serial divider of the bias correction block.
`default_nettype none
module gbc_datapath #(
	parameter int COUNT_BITS = gbc_pkg::COUNT_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire gbc_pkg::cmd_t                    cmd,
	output gbc_pkg::stat_t                        stat,
	input  wire logic signed [15:0]               raw_rate,
	input  wire logic [23:0]                      scale,
	input  wire logic                             invert,
	input  wire logic [15:0]                      track_gain,
	output logic signed [gbc_pkg::VAL_BITS-1:0]   rate_out,
	output logic signed [gbc_pkg::VAL_BITS-1:0]   raw_dps,
	output logic signed [gbc_pkg::VAL_BITS-1:0]   bias_out,
	output logic                                  ok,
	output logic                                  calibrating
);
	import gbc_pkg::*;

	localparam int SUM_BITS = VAL_BITS + COUNT_BITS;
	localparam logic [SUM_BITS-1:0] POS_LIM = SUM_BITS'(20'h7FFFF);
	localparam logic [SUM_BITS-1:0] NEG_LIM = SUM_BITS'(21'h80000);

	// architectural state
	logic signed [VAL_BITS-1:0] last_raw_q, bias_q, saved_q, last_rate_q;
	logic signed [SUM_BITS-1:0] sum_q;
	logic [COUNT_BITS-1:0]      count_q;
	logic                       active_q;

	// working registers
	logic signed [15:0]         raw_q;
	logic signed [20:0]         diff_q;
	logic signed [45:0]         prod_q;
	logic [SUM_BITS-1:0]        dvd_q;
	logic [COUNT_BITS-1:0]      rem_q;
	logic                       neg_q;

	// result registers
	logic signed [VAL_BITS-1:0] rate_out_q, raw_dps_q, bias_out_q;
	logic                       ok_out_q, cal_out_q;

	logic signed [20:0]         cur_diff;
	logic signed [21:0]         rate_pre;
	logic signed [20:0]         mul_a;
	logic signed [24:0]         mul_b;
	logic signed [29:0]         prod_sh;
	logic signed [30:0]         learn_sum;
	logic [SUM_BITS-1:0]        sum_mag;
	logic [COUNT_BITS:0]        trial, trial_sub;
	logic                       trial_ge;
	logic [VAL_BITS-1:0]        neg_low;
	logic signed [VAL_BITS-1:0] div_res;
	logic                       count_full;

	assign cur_diff = {last_raw_q[VAL_BITS-1], last_raw_q} - {bias_q[VAL_BITS-1], bias_q};
	assign rate_pre = invert ? -{cur_diff[20], cur_diff} : {cur_diff[20], cur_diff};

	assign mul_a = cmd.mul_learn ? diff_q : {{5{raw_q[15]}}, raw_q};
	assign mul_b = cmd.mul_learn ? $signed({9'b0, track_gain}) : $signed({1'b0, scale});

	// arithmetic shift right 16 floors toward minus infinity
	assign prod_sh   = prod_q[45:16];
	assign learn_sum = {{11{bias_q[VAL_BITS-1]}}, bias_q} + {prod_sh[29], prod_sh};

	assign count_full = (count_q == {COUNT_BITS{1'b1}});
	assign sum_mag    = sum_q[SUM_BITS-1] ? (~sum_q + 1'b1) : sum_q;

	// restoring division step on the magnitude
	assign trial     = {rem_q, dvd_q[SUM_BITS-1]};
	assign trial_ge  = (trial >= {1'b0, count_q});
	assign trial_sub = trial - {1'b0, count_q};

	assign neg_low = ~dvd_q[VAL_BITS-1:0] + 1'b1;

	always_comb begin
		if (neg_q) begin
			div_res = (dvd_q > NEG_LIM) ? VAL_MIN : neg_low;
		end else begin
			div_res = (dvd_q > POS_LIM) ? VAL_MAX : dvd_q[VAL_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_raw_q  <= '0;
			bias_q      <= '0;
			saved_q     <= '0;
			last_rate_q <= '0;
			sum_q       <= '0;
			count_q     <= '0;
			active_q    <= 1'b0;
		end else if (cmd.scale) begin
			last_raw_q <= sat_val({{2{prod_sh[29]}}, prod_sh});
		end else if (cmd.rate) begin
			last_rate_q <= sat_val({{10{rate_pre[21]}}, rate_pre});
			if (active_q && !count_full) begin
				sum_q   <= sum_q + {{(SUM_BITS-VAL_BITS){last_raw_q[VAL_BITS-1]}}, last_raw_q};
				count_q <= count_q + 1'b1;
			end
		end else if (cmd.learn) begin
			bias_q <= sat_val({learn_sum[30], learn_sum});
		end else if (cmd.cal_start) begin
			if (!active_q) begin
				saved_q <= bias_q;
			end
			bias_q   <= '0;
			sum_q    <= '0;
			count_q  <= '0;
			active_q <= 1'b1;
		end else if (cmd.cal_fail) begin
			bias_q   <= saved_q;
			active_q <= 1'b0;
		end else if (cmd.div_end) begin
			bias_q      <= div_res;
			last_rate_q <= '0;
			active_q    <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			raw_q  <= raw_rate;
			diff_q <= cur_diff;
		end
		if (cmd.mul) begin
			prod_q <= mul_a * mul_b;
		end
		if (cmd.div_load) begin
			dvd_q <= sum_mag;
			rem_q <= '0;
			neg_q <= sum_q[SUM_BITS-1];
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[SUM_BITS-2:0], trial_ge};
			rem_q <= trial_ge ? trial_sub[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
		end
		if (cmd.load_out) begin
			rate_out_q <= last_rate_q;
			raw_dps_q  <= last_raw_q;
			bias_out_q <= bias_q;
			ok_out_q   <= cmd.ok;
			cal_out_q  <= active_q;
		end
	end

	assign stat.cal_active = active_q;
	assign stat.count_zero = (count_q == '0);

	assign rate_out    = rate_out_q;
	assign raw_dps     = raw_dps_q;
	assign bias_out    = bias_out_q;
	assign ok          = ok_out_q;
	assign calibrating = cal_out_q;

endmodule
`default_nettype wire

// ===== rtl/gyro_rate_bias_correction.sv =====
// Items step through the sequencer to out_valid: a sample via multiply, scale and rate; a learn
// via multiply and learn; a calibration start or empty finish via its start or fail step; a
// failed read or finish while idle straight to write; other finishes via divider load, the serial
// divider (one bit of the 20+COUNT_BITS bit sum per step) and divider end. One item at a time;
// the next is taken once the result is in the output register, even while it waits for out_ready.
// Reset (arst_n low, asynchronous): bias, sums and flags clear, registers take defaults.
`default_nettype none
module gyro_rate_bias_correction #(
	parameter int COUNT_BITS = gbc_pkg::COUNT_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// APB-style register port
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [gbc_pkg::PADDR_W-1:0]    paddr,
	input  wire logic [31:0]                    pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready,
	// input items
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [1:0]                     func,
	input  wire logic signed [15:0]             raw_rate,
	input  wire logic                           read_ok,
	// result items
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic signed [gbc_pkg::VAL_BITS-1:0] rate_out,
	output logic signed [gbc_pkg::VAL_BITS-1:0] raw_dps,
	output logic signed [gbc_pkg::VAL_BITS-1:0] bias_out,
	output logic                                ok,
	output logic                                calibrating
);
	import gbc_pkg::*;

	logic [23:0] scale_q;
	logic        invert_q;
	logic [15:0] learn_q;
	logic        reg_wr;
	cmd_t        cmd;
	stat_t       stat;

	// A register write lands on the access phase of the transfer.
	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q  <= SCALE_RESET;
			invert_q <= 1'b0;
			learn_q  <= '0;
		end else if (reg_wr) begin
			unique case (paddr[3:2])
				REG_SCALE:  scale_q  <= pwdata[23:0];
				REG_INVERT: invert_q <= pwdata[0];
				REG_LEARN:  learn_q  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Read back: zero-extend each register, unused slots read zero.
	always_comb begin
		unique case (paddr[3:2])
			REG_SCALE:  prdata = {8'b0, scale_q};
			REG_INVERT: prdata = {31'b0, invert_q};
			REG_LEARN:  prdata = {16'b0, learn_q};
			default:    prdata = '0;
		endcase
	end

	// The sequencer steps through each function; the datapath holds the bias and calibration state.
	gbc_ctrl #(
		.COUNT_BITS(COUNT_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.func     (func),
		.read_ok  (read_ok),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	gbc_datapath #(
		.COUNT_BITS(COUNT_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.raw_rate   (raw_rate),
		.scale      (scale_q),
		.invert     (invert_q),
		.track_gain (learn_q),
		.rate_out   (rate_out),
		.raw_dps    (raw_dps),
		.bias_out   (bias_out),
		.ok         (ok),
		.calibrating(calibrating)
	);

endmodule
`default_nettype wire

// ===== bench/gbc_checker.sv =====
// Result checker for the gyro rate bias correction block.
module gbc_checker #(
	parameter int COUNT_BITS = gbc_pkg::COUNT_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [gbc_pkg::PADDR_W-1:0]    paddr,
	input  wire logic [31:0]                    pwdata,
	input  wire logic [31:0]                    prdata,
	input  wire logic                           pready,
	input  wire logic                           in_valid,
	input  wire logic                           in_ready,
	input  wire logic [1:0]                     func,
	input  wire logic signed [15:0]             raw_rate,
	input  wire logic                           read_ok,
	input  wire logic                           out_valid,
	input  wire logic                           out_ready,
	input  wire logic signed [gbc_pkg::VAL_BITS-1:0] rate_out,
	input  wire logic signed [gbc_pkg::VAL_BITS-1:0] raw_dps,
	input  wire logic signed [gbc_pkg::VAL_BITS-1:0] bias_out,
	input  wire logic                           ok,
	input  wire logic                           calibrating,
	output int unsigned                         pending = 0,
	output int unsigned                         fail_count = 0
);
	import gbc_pkg::*;

	typedef struct packed {
		logic signed [VAL_BITS-1:0] rate;
		logic signed [VAL_BITS-1:0] raw;
		logic signed [VAL_BITS-1:0] bias;
		logic                       ok;
		logic                       cal;
	} gyro_result_t;

	localparam longint COUNT_MAX = (longint'(1) << COUNT_BITS) - 1;

	// register copies
	logic [23:0] scale_reg;
	logic        invert_reg;
	logic [15:0] learn_reg;

	// predicted block state
	logic signed [VAL_BITS-1:0] raw_dps_st;
	logic signed [VAL_BITS-1:0] bias_st;
	logic signed [VAL_BITS-1:0] saved_bias_st;
	logic signed [VAL_BITS-1:0] rate_st;
	longint                     cal_sum_st;
	longint                     cal_count_st;
	logic                       cal_active_st;

	gyro_result_t predicted_q[$];

	function automatic logic signed [VAL_BITS-1:0] clamp_val(input longint v);
		if (v > 64'sd524287) begin
			return VAL_MAX;
		end else if (v < -64'sd524288) begin
			return VAL_MIN;
		end
		return VAL_BITS'(v);
	endfunction

	function automatic logic [31:0] reg_value(input logic [1:0] idx);
		case (idx)
			REG_SCALE:  return {8'h00, scale_reg};
			REG_INVERT: return {31'h0, invert_reg};
			REG_LEARN:  return {16'h0000, learn_reg};
			default:    return 32'h0;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		longint       prod;
		longint       diff;
		logic         good;
		gyro_result_t want;
		gyro_result_t got;
		if (!arst_n) begin
			scale_reg     = SCALE_RESET;
			invert_reg    = 1'b0;
			learn_reg     = 16'h0000;
			raw_dps_st    = '0;
			bias_st       = '0;
			saved_bias_st = '0;
			rate_st       = '0;
			cal_sum_st    = 0;
			cal_count_st  = 0;
			cal_active_st = 1'b0;
			predicted_q.delete();
			pending <= 0;
		end else begin
			// register port: update copies on write, compare on read
			if (psel && penable && pready) begin
				if (pwrite) begin
					case (paddr[3:2])
						REG_SCALE:  scale_reg  = pwdata[23:0];
						REG_INVERT: invert_reg = pwdata[0];
						REG_LEARN:  learn_reg  = pwdata[15:0];
						default: ;
					endcase
				end else if (prdata !== reg_value(paddr[3:2])) begin
					if (fail_count < 10)
						$display("gbc_checker: register %0d read: expected %0h, got %0h",
							paddr[3:2], reg_value(paddr[3:2]), prdata);
					fail_count++;
				end
			end

			// result transfer: compare with the oldest prediction
			if (out_valid && out_ready) begin
				got = '{rate_out, raw_dps, bias_out, ok, calibrating};
				if (predicted_q.size() == 0) begin
					if (fail_count < 10)
						$display("gbc_checker: result with nothing predicted: rate %0d raw %0d",
							rate_out, raw_dps);
					fail_count++;
				end else begin
					want = predicted_q.pop_front();
					if (got !== want) begin
						if (fail_count < 10)
							$display({"gbc_checker: mismatch: expected rate %0d raw %0d ",
								"bias %0d ok %0b cal %0b, got rate %0d raw %0d bias %0d ",
								"ok %0b cal %0b"},
								want.rate, want.raw, want.bias, want.ok, want.cal,
								got.rate, got.raw, got.bias, got.ok, got.cal);
						fail_count++;
					end
				end
			end

			// item transfer: advance the predicted state
			if (in_valid && in_ready) begin
				good = 1'b1;
				case (func_t'(func))
					FUNC_SAMPLE: begin
						if (read_ok) begin
							prod = longint'(raw_rate) * longint'(scale_reg);
							raw_dps_st = clamp_val(prod >>> 16);
							diff = longint'(raw_dps_st) - longint'(bias_st);
							rate_st = clamp_val(invert_reg ? -diff : diff);
							// hold sum and count once the count is full
							if (cal_active_st && cal_count_st < COUNT_MAX) begin
								cal_sum_st += longint'(raw_dps_st);
								cal_count_st++;
							end
						end else begin
							good = 1'b0;
						end
					end
					FUNC_CAL_START: begin
						if (!cal_active_st)
							saved_bias_st = bias_st;
						bias_st       = '0;
						cal_sum_st    = 0;
						cal_count_st  = 0;
						cal_active_st = 1'b1;
					end
					FUNC_CAL_FINISH: begin
						if (!cal_active_st) begin
							good = 1'b0;
						end else begin
							cal_active_st = 1'b0;
							if (cal_count_st == 0) begin
								bias_st = saved_bias_st;
								good    = 1'b0;
							end else begin
								bias_st = clamp_val(cal_sum_st / cal_count_st);
								rate_st = '0;
							end
						end
					end
					default: begin
						diff = longint'(raw_dps_st) - longint'(bias_st);
						bias_st = clamp_val(longint'(bias_st) +
							((diff * longint'(learn_reg)) >>> 16));
					end
				endcase
				predicted_q.push_back('{rate_st, raw_dps_st, bias_st, good, cal_active_st});
			end
			pending <= predicted_q.size();
		end
	end

endmodule

// ===== bench/tb_top.sv =====
// Top of the gyro rate bias correction testbench: stimulus, clock, reset and verdict.
module tb_top;
	import gbc_pkg::*;

	localparam int COUNT_BITS = COUNT_BITS_DEF;
	// samples in the long calibration run
	localparam int SAT_SAMPLES = 200;
	localparam int RANDOM_PER_PHASE = 420;

	logic                       clk;
	logic                       arst_n;
	logic                       psel;
	logic                       penable;
	logic                       pwrite;
	logic [PADDR_W-1:0]         paddr;
	logic [31:0]                pwdata;
	logic [31:0]                prdata;
	logic                       pready;
	logic                       in_valid;
	logic                       in_ready;
	logic [1:0]                 func;
	logic signed [15:0]         raw_rate;
	logic                       read_ok;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic signed [VAL_BITS-1:0] rate_out;
	logic signed [VAL_BITS-1:0] raw_dps;
	logic signed [VAL_BITS-1:0] bias_out;
	logic                       ok;
	logic                       calibrating;

	int unsigned pending;
	int unsigned fail_count;
	int          send_idle_pct = 0;
	int          stall_pct = 0;
	int unsigned items_sent = 0;

	gyro_rate_bias_correction #(
		.COUNT_BITS(COUNT_BITS)
	) DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .raw_rate(raw_rate), .read_ok(read_ok),
		.out_valid(out_valid), .out_ready(out_ready),
		.rate_out(rate_out), .raw_dps(raw_dps), .bias_out(bias_out),
		.ok(ok), .calibrating(calibrating)
	);

	gbc_checker #(
		.COUNT_BITS(COUNT_BITS)
	) u_checker (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .raw_rate(raw_rate), .read_ok(read_ok),
		.out_valid(out_valid), .out_ready(out_ready),
		.rate_out(rate_out), .raw_dps(raw_dps), .bias_out(bias_out),
		.ok(ok), .calibrating(calibrating),
		.pending(pending), .fail_count(fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Drop out_ready at random; the stall percentage follows the current phase.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Bound the run: about two thousand items, even if each took a full divider
	// pass under the heaviest stalls, need a small fraction of this.
	initial begin
		#16000000;
		$display("tb_top: FAIL");
		$finish;
	end

	// Pick a gyro sample: rail values, values around zero, or any 16-bit pattern.
	function automatic logic signed [15:0] rand_raw();
		int s;
		case ($urandom_range(9))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: begin
				s = int'($urandom_range(16)) - 8;
				return 16'(s);
			end
			default: return 16'($urandom);
		endcase
	endfunction

	// Present one item and hold it until the transfer. Idle first at random;
	// valid is lowered only when an idle gap follows, so a back-to-back item
	// keeps it high through the edge.
	task automatic send_gyro_item(input func_t f, input logic signed [15:0] r,
			input logic rok);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		func     <= f;
		raw_rate <= r;
		read_ok  <= rok;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	// Drop valid and wait until every predicted result has come back.
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	// One register access: setup cycle, then access cycle until pready.
	// Return the bus to idle after it so back-to-back accesses never
	// retarget psel within the same edge.
	task automatic reg_access(input logic wr, input logic [1:0] idx,
			input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Write all three registers, then read each back for the checker.
	task automatic program_regs(input logic [23:0] scale, input logic inv,
			input logic [15:0] learn);
		reg_access(1'b1, REG_SCALE, {8'h00, scale});
		reg_access(1'b1, REG_INVERT, {31'h0, inv});
		reg_access(1'b1, REG_LEARN, {16'h0000, learn});
		reg_access(1'b0, REG_SCALE, 32'h0);
		reg_access(1'b0, REG_INVERT, 32'h0);
		reg_access(1'b0, REG_LEARN, 32'h0);
	endtask

	initial begin : stimulus
		int          p;
		int          i;
		int          n;
		int          pick;
		int unsigned start;

		arst_n   <= 1'b0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		in_valid <= 1'b0;
		func     <= FUNC_SAMPLE;
		raw_rate <= '0;
		read_ok  <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed part on the reset register values.
		reg_access(1'b0, REG_SCALE, 32'h0);
		reg_access(1'b0, REG_INVERT, 32'h0);
		reg_access(1'b0, REG_LEARN, 32'h0);
		// finish while not calibrating
		send_gyro_item(FUNC_CAL_FINISH, 16'sd0, 1'b1);
		// failed read leaves everything alone
		send_gyro_item(FUNC_SAMPLE, 16'sh7FFF, 1'b0);
		send_gyro_item(FUNC_SAMPLE, 16'sh7FFF, 1'b1);
		send_gyro_item(FUNC_SAMPLE, 16'sh8000, 1'b1);
		send_gyro_item(FUNC_SAMPLE, 16'sd0, 1'b1);
		send_gyro_item(FUNC_SAMPLE, -16'sd1, 1'b1);
		send_gyro_item(FUNC_LEARN, 16'sd0, 1'b1);
		// finish with no samples restores the saved bias
		send_gyro_item(FUNC_CAL_START, 16'sd0, 1'b1);
		send_gyro_item(FUNC_CAL_FINISH, 16'sd0, 1'b1);
		send_gyro_item(FUNC_CAL_START, 16'sd0, 1'b1);
		send_gyro_item(FUNC_SAMPLE, 16'sd100, 1'b1);
		send_gyro_item(FUNC_SAMPLE, -16'sd300, 1'b1);
		send_gyro_item(FUNC_SAMPLE, 16'sd7, 1'b0);
		// start while calibrating restarts the sum and keeps the first saved bias
		send_gyro_item(FUNC_CAL_START, 16'sd0, 1'b1);
		send_gyro_item(FUNC_SAMPLE, 16'sd5000, 1'b1);
		send_gyro_item(FUNC_SAMPLE, 16'sh8000, 1'b1);
		// learn while calibrating
		send_gyro_item(FUNC_LEARN, 16'sd0, 1'b1);
		send_gyro_item(FUNC_CAL_FINISH, 16'sd0, 1'b1);
		send_gyro_item(FUNC_SAMPLE, 16'sd1, 1'b1);
		// empty calibration now restores a nonzero bias
		send_gyro_item(FUNC_CAL_START, 16'sd0, 1'b1);
		send_gyro_item(FUNC_CAL_FINISH, 16'sd0, 1'b1);

		for (p = 0; p < 4; p++) begin
			settle();
			case (p)
				0: begin
					program_regs(24'hFFFFFF, 1'b1, 16'hFFFF);
					send_idle_pct = 0;
					stall_pct <= 0;
				end
				1: begin
					program_regs(24'h000000, 1'b0, 16'h8000);
					send_idle_pct = 74;
					stall_pct <= 0;
				end
				2: begin
					program_regs(SCALE_RESET, 1'b1, 16'h0000);
					send_idle_pct = 0;
					stall_pct <= 74;
				end
				default: begin
					program_regs(24'($urandom_range(24'hFFFFFF)), 1'($urandom_range(1)),
						16'($urandom_range(16'hFFFF)));
					send_idle_pct = 8;
					stall_pct <= 8;
				end
			endcase

			// Run a long calibration with rail-heavy samples at maximum scale,
			// so the sum is wide when the divider runs.
			if (p == 0) begin
				send_gyro_item(FUNC_CAL_START, 16'sd0, 1'b1);
				for (i = 0; i < SAT_SAMPLES; i++)
					send_gyro_item(FUNC_SAMPLE, rand_raw(), 1'b1);
				send_gyro_item(FUNC_LEARN, 16'sd0, 1'b1);
				send_gyro_item(FUNC_CAL_FINISH, 16'sd0, 1'b1);
			end

			start = items_sent;
			while (items_sent - start < RANDOM_PER_PHASE) begin
				if ($urandom_range(99) < 65) begin
					// calibration with a short burst of samples, then tracking
					send_gyro_item(FUNC_CAL_START, rand_raw(), 1'($urandom_range(1)));
					n = $urandom_range(12);
					for (i = 0; i < n; i++) begin
						pick = $urandom_range(99);
						if (pick < 8)
							send_gyro_item(FUNC_SAMPLE, rand_raw(), 1'b0);
						else if (pick < 14)
							send_gyro_item(FUNC_LEARN, rand_raw(), 1'($urandom_range(1)));
						else if (pick < 17)
							send_gyro_item(FUNC_CAL_START, rand_raw(), 1'b1);
						else
							send_gyro_item(FUNC_SAMPLE, rand_raw(), 1'b1);
					end
					// leave some calibrations open on purpose
					if ($urandom_range(9) != 0)
						send_gyro_item(FUNC_CAL_FINISH, rand_raw(), 1'($urandom_range(1)));
					n = $urandom_range(4, 1);
					for (i = 0; i < n; i++)
						send_gyro_item(($urandom_range(3) == 0) ? FUNC_LEARN : FUNC_SAMPLE,
							rand_raw(), 1'b1);
				end else begin
					// noise: any operation with any field values
					send_gyro_item(func_t'($urandom_range(3)), rand_raw(),
						1'($urandom_range(1)));
				end
			end
		end

		// Drain, then give the block a full divider latency to show stray results.
		settle();
		repeat (48) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/gbc_pkg.sv
rtl/gbc_ctrl.sv
rtl/gbc_datapath.sv
rtl/gyro_rate_bias_correction.sv
bench/gbc_checker.sv
bench/tb_top.sv
